// ----- rtl/char_class_tokenizer_defines.svh -----
// Assertion macros shared by the tokenizer checker.
`ifndef CHAR_CLASS_TOKENIZER_DEFINES_SVH
`define CHAR_CLASS_TOKENIZER_DEFINES_SVH

// Property checked at every rising edge while reset is released.
`define CCT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("char_class_tokenizer: property violated");

// Property checked at every rising edge, reset included.
`define CCT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("char_class_tokenizer: property violated");

`endif

// ----- rtl/cct_pkg.sv -----
// Types, codes and the character classifier shared by the tokenizer modules.
package cct_pkg;

    // Token class codes as they appear on the result channel.
    localparam logic [3:0] CLASS_SPACE  = 4'd0;
    localparam logic [3:0] CLASS_NUMBER = 4'd1;
    localparam logic [3:0] CLASS_NAME   = 4'd2;
    localparam logic [3:0] CLASS_DOT    = 4'd3;
    localparam logic [3:0] CLASS_OPEN   = 4'd4;
    localparam logic [3:0] CLASS_CLOSE  = 4'd5;
    localparam logic [3:0] CLASS_CODE   = 4'd6;
    localparam logic [3:0] CLASS_TEXT   = 4'd7;
    localparam logic [3:0] CLASS_END    = 4'd8;
    localparam logic [3:0] CLASS_OTHER  = 4'd9;

    localparam logic [7:0] CHAR_QUOTE  = 8'h27;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_OPEN   = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE  = 8'h5D;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;

    typedef enum logic [2:0] {
        MODE_NONE   = 3'd0,
        MODE_SPACE  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_NAME   = 3'd3,
        MODE_TEXT   = 3'd4,
        MODE_ESCAPE = 3'd5
    } lex_mode_t;

    typedef enum logic [3:0] {
        KIND_WS,
        KIND_DIGIT,
        KIND_LETTER,
        KIND_QUOTE,
        KIND_DOT,
        KIND_OPEN,
        KIND_CLOSE,
        KIND_SLASH,
        KIND_SEMI,
        KIND_OTHER
    } char_kind_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       text_begin;
    } char_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [3:0] token_class;
        logic       token_first;
    } token_item_t;

    function automatic char_kind_t char_kind(input logic [7:0] c);
        char_kind_t k;
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
            k = KIND_WS;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            k = KIND_DIGIT;
        end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
            k = KIND_LETTER;
        end else if (c == CHAR_QUOTE) begin
            k = KIND_QUOTE;
        end else if (c == CHAR_DOT) begin
            k = KIND_DOT;
        end else if (c == CHAR_OPEN) begin
            k = KIND_OPEN;
        end else if (c == CHAR_CLOSE) begin
            k = KIND_CLOSE;
        end else if (c == CHAR_SLASH) begin
            k = KIND_SLASH;
        end else if (c == CHAR_SEMI) begin
            k = KIND_SEMI;
        end else begin
            k = KIND_OTHER;
        end
        return k;
    endfunction

endpackage

// ----- rtl/char_class_tokenizer.sv -----
// Top level of the character class tokenizer.
//
//   channel   direction  tdata            tuser
//   s_        in         char_byte[7:0]   text_begin[0]
//   m_        out        out_byte[7:0]    token_class[3:0], token_first[4]
//
// One byte enters per cycle while m_tready is high; its tagged result passes through
// the input register and then the result register around the lexer logic.
// The lexer mode register carries the only state from byte to byte, so a full
// rate of one byte per cycle holds without gaps while m_tready stays high.
// Reset (aresetn low at a rising edge) empties both registers and clears the mode.
// A stall on m_tready holds the result; one more byte waits in the input register.
module char_class_tokenizer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic [0:0] s_tuser,   // [0] text_begin
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [4:0] m_tuser    // [3:0] token_class, [4] token_first
);

    cct_pkg::char_item_t  s_item;
    cct_pkg::char_item_t  item;
    cct_pkg::token_item_t token;
    cct_pkg::token_item_t m_item;
    logic                 item_valid;
    logic                 token_ready;
    logic                 advance;

    assign s_item.char_byte  = s_tdata;
    assign s_item.text_begin = s_tuser[0];

    // A byte moves into the result register and updates the mode in one transfer.
    assign advance = item_valid && token_ready;

    cct_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (advance)
    );

    cct_lexer u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .advance (advance),
        .token   (token)
    );

    cct_out_stage u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .token_valid (item_valid),
        .token       (token),
        .token_ready (token_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_item      (m_item)
    );

    assign m_tdata = m_item.out_byte;
    assign m_tuser = {m_item.token_first, m_item.token_class};

endmodule

// ----- rtl/cct_in_stage.sv -----
// Input register of the tokenizer: holds one accepted byte until the lexer takes it.
module cct_in_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  cct_pkg::char_item_t  s_item,
    output logic                 item_valid,
    output cct_pkg::char_item_t  item,
    input  logic                 item_take
);

    logic                valid_reg;
    logic                valid_next;
    cct_pkg::char_item_t item_reg;

    // The register may refill in the same cycle that its content moves on.
    assign s_tready   = !valid_reg || item_take;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- rtl/cct_lexer.sv -----
// Lexer mode register and the per-byte classification logic.
module cct_lexer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cct_pkg::char_item_t   item,
    input  logic                  advance,
    output cct_pkg::token_item_t  token
);

    cct_pkg::lex_mode_t mode_reg;
    cct_pkg::lex_mode_t mode_next;
    cct_pkg::lex_mode_t mode_cur;
    cct_pkg::char_kind_t kind;

    // A new text starts from an empty mode before its first byte is looked at.
    assign mode_cur = item.text_begin ? cct_pkg::MODE_NONE : mode_reg;
    assign kind     = cct_pkg::char_kind(item.char_byte);

    always_comb begin
        unique case (mode_cur)
            cct_pkg::MODE_TEXT: begin
                if (item.char_byte == cct_pkg::CHAR_BSLASH) begin
                    mode_next = cct_pkg::MODE_ESCAPE;
                end else if (item.char_byte == cct_pkg::CHAR_QUOTE) begin
                    mode_next = cct_pkg::MODE_NONE;
                end else begin
                    mode_next = cct_pkg::MODE_TEXT;
                end
            end
            cct_pkg::MODE_ESCAPE: begin
                mode_next = cct_pkg::MODE_TEXT;
            end
            default: begin
                unique case (kind)
                    cct_pkg::KIND_WS:     mode_next = cct_pkg::MODE_SPACE;
                    cct_pkg::KIND_DIGIT: begin
                        mode_next = (mode_cur == cct_pkg::MODE_NAME) ? cct_pkg::MODE_NAME
                                                                     : cct_pkg::MODE_NUMBER;
                    end
                    cct_pkg::KIND_LETTER: mode_next = cct_pkg::MODE_NAME;
                    cct_pkg::KIND_QUOTE:  mode_next = cct_pkg::MODE_TEXT;
                    default:              mode_next = cct_pkg::MODE_NONE;
                endcase
            end
        endcase
    end

    always_comb begin
        token.out_byte = item.char_byte;
        unique case (mode_cur)
            cct_pkg::MODE_TEXT, cct_pkg::MODE_ESCAPE: begin
                token.token_class = cct_pkg::CLASS_TEXT;
                token.token_first = 1'b0;
            end
            default: begin
                token.token_first = 1'b1;
                unique case (kind)
                    cct_pkg::KIND_WS: begin
                        token.token_class = cct_pkg::CLASS_SPACE;
                        token.token_first = (mode_cur != cct_pkg::MODE_SPACE);
                    end
                    cct_pkg::KIND_DIGIT: begin
                        // Digits after letters stay in the name.
                        if (mode_cur == cct_pkg::MODE_NAME) begin
                            token.token_class = cct_pkg::CLASS_NAME;
                            token.token_first = 1'b0;
                        end else begin
                            token.token_class = cct_pkg::CLASS_NUMBER;
                            token.token_first = (mode_cur != cct_pkg::MODE_NUMBER);
                        end
                    end
                    cct_pkg::KIND_LETTER: begin
                        token.token_class = cct_pkg::CLASS_NAME;
                        token.token_first = (mode_cur != cct_pkg::MODE_NAME);
                    end
                    cct_pkg::KIND_QUOTE: token.token_class = cct_pkg::CLASS_TEXT;
                    cct_pkg::KIND_DOT:   token.token_class = cct_pkg::CLASS_DOT;
                    cct_pkg::KIND_OPEN:  token.token_class = cct_pkg::CLASS_OPEN;
                    cct_pkg::KIND_CLOSE: token.token_class = cct_pkg::CLASS_CLOSE;
                    cct_pkg::KIND_SLASH: token.token_class = cct_pkg::CLASS_CODE;
                    cct_pkg::KIND_SEMI:  token.token_class = cct_pkg::CLASS_END;
                    default:             token.token_class = cct_pkg::CLASS_OTHER;
                endcase
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= cct_pkg::MODE_NONE;
        end else if (advance) begin
            mode_reg <= mode_next;
        end
    end

endmodule

// ----- rtl/cct_out_stage.sv -----
// Result register of the tokenizer, driving the master side of the stream.
module cct_out_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  token_valid,
    input  cct_pkg::token_item_t  token,
    output logic                  token_ready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output cct_pkg::token_item_t  m_item
);

    logic                 valid_reg;
    logic                 valid_next;
    cct_pkg::token_item_t item_reg;
    logic                 load;

    assign token_ready = !valid_reg || m_tready;
    assign load        = token_valid && token_ready;
    assign valid_next  = load ? 1'b1 : ((valid_reg && m_tready) ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= token;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_item   = item_reg;

endmodule

// ----- rtl/cct_checker.sv -----
// Port-level checker for the tokenizer and its bind to the top level.
`include "char_class_tokenizer_defines.svh"

module cct_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic [0:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [4:0] m_tuser
);

    logic [3:0] m_class;
    logic       m_first;
    logic       m_stall;
    logic       m_dot;
    logic       single_tok;
    logic       s_xfer;

    assign m_class    = m_tuser[3:0];
    assign m_first    = m_tuser[4];
    assign m_stall    = m_tvalid && !m_tready;
    assign m_dot      = m_tvalid && (m_class == cct_pkg::CLASS_DOT);
    assign s_xfer     = s_tvalid && s_tready;
    assign single_tok = (m_class == cct_pkg::CLASS_DOT) || (m_class == cct_pkg::CLASS_OPEN)
                     || (m_class == cct_pkg::CLASS_CLOSE) || (m_class == cct_pkg::CLASS_CODE)
                     || (m_class == cct_pkg::CLASS_END);

    // A held result must not change while the sink stalls.
    `CCT_ASSERT(a_stall_hold, aclk, aresetn, m_stall |=> m_tvalid && $stable({m_tdata, m_tuser}))
    // Reset leaves no result on the output.
    `CCT_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    // Single-character tokens always start a token.
    `CCT_ASSERT(a_single_first, aclk, aresetn, m_tvalid && single_tok |-> m_first)
    // The dot class is given to the dot character only.
    `CCT_ASSERT(a_dot_byte, aclk, aresetn, m_dot |-> m_tdata == cct_pkg::CHAR_DOT)
    // Every accepted byte carries defined data.
    `CCT_ASSERT(a_in_known, aclk, aresetn, s_xfer |-> !$isunknown({s_tdata, s_tuser}))

endmodule

bind char_class_tokenizer cct_checker u_cct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
